// File: hw/rtl/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
// No dependencies; imported by every lpg module.
package lpg_pkg;

  localparam int COORD_BITS = 11;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int WIDTH_BITS = 11;
  localparam int DATA_BITS  = 32;
  localparam int LIN_BITS   = COORD_BITS + WIDTH_BITS + 1;

  localparam logic [DATA_BITS-1:0]  BASE0_RESET = 32'hC020_0000;
  localparam logic [DATA_BITS-1:0]  BASE1_RESET = 32'hC000_0000;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 11'd480;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_BASE0 = 2'd0,
    CFG_BASE1 = 2'd1,
    CFG_WIDTH = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [DATA_BITS-1:0]  color;
    logic                  layer;
    logic                  last;
  } pixel_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]  base0;
    logic [DATA_BITS-1:0]  base1;
    logic [WIDTH_BITS-1:0] width;
  } cfg_t;

endpackage

// File: hw/rtl/lpg_stepper.sv
// Line state and combinational Bresenham step; registers the pixel beat.
// Depends on lpg_pkg.
module lpg_stepper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [lpg_pkg::COORD_BITS-1:0] in_start_x,
  input  logic [lpg_pkg::COORD_BITS-1:0] in_start_y,
  input  logic [lpg_pkg::COORD_BITS-1:0] in_end_x,
  input  logic [lpg_pkg::COORD_BITS-1:0] in_end_y,
  input  logic [lpg_pkg::DATA_BITS-1:0]  in_color,
  input  logic                          in_layer,
  input  logic                          s1_take,
  output logic                          s1_valid,
  output lpg_pkg::pixel_t               s1_pix
);
  import lpg_pkg::*;

  localparam int W = ERR_BITS + 1;

  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [COORD_BITS-1:0] span_x_r, span_x_nxt, span_y_r, span_y_nxt;
  logic                  left_r, left_nxt, up_r, up_nxt;
  logic [ERR_BITS-1:0]   err_r, err_nxt;
  logic [DATA_BITS-1:0]  color_r, color_nxt;
  logic                  layer_r, layer_nxt;
  logic                  active_r, active_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  pixel_t                s1_pix_r, s1_pix_nxt;

  logic                  adv, is_start, fire, at_end, move_x, move_y;
  logic signed [W-1:0]   e2, neg_spy, spx_s, e_sum;

  assign adv      = !s1_valid_r || s1_take;
  assign in_ready = adv;
  assign is_start = (in_cmd == CMD_START);
  assign fire     = in_valid && adv && (is_start || active_r);

  always_comb begin
    e2      = $signed({err_r, 1'b0});
    neg_spy = -$signed(W'(span_y_r));
    spx_s   = $signed(W'(span_x_r));
    move_x  = e2 > neg_spy;
    move_y  = e2 < spx_s;
    e_sum   = $signed({err_r[ERR_BITS-1], err_r})
              + (move_x ? neg_spy : '0)
              + (move_y ? spx_s : '0);

    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    tgt_x_nxt   = tgt_x_r;
    tgt_y_nxt   = tgt_y_r;
    span_x_nxt  = span_x_r;
    span_y_nxt  = span_y_r;
    left_nxt    = left_r;
    up_nxt      = up_r;
    err_nxt     = err_r;
    color_nxt   = color_r;
    layer_nxt   = layer_r;

    if (is_start) begin
      cur_x_nxt  = in_start_x;
      cur_y_nxt  = in_start_y;
      tgt_x_nxt  = in_end_x;
      tgt_y_nxt  = in_end_y;
      left_nxt   = !(in_start_x < in_end_x);
      up_nxt     = !(in_start_y < in_end_y);
      span_x_nxt = left_nxt ? in_start_x - in_end_x : in_end_x - in_start_x;
      span_y_nxt = up_nxt ? in_start_y - in_end_y : in_end_y - in_start_y;
      err_nxt    = ERR_BITS'(span_x_nxt) - ERR_BITS'(span_y_nxt);
      color_nxt  = in_color;
      layer_nxt  = in_layer;
    end else begin
      if (move_x) cur_x_nxt = left_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
      if (move_y) cur_y_nxt = up_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
      err_nxt = e_sum[ERR_BITS-1:0];
    end

    at_end     = (cur_x_nxt == tgt_x_nxt) && (cur_y_nxt == tgt_y_nxt);
    active_nxt = fire ? !at_end : active_r;

    s1_pix_nxt.x     = cur_x_nxt;
    s1_pix_nxt.y     = cur_y_nxt;
    s1_pix_nxt.color = color_nxt;
    s1_pix_nxt.layer = layer_nxt;
    s1_pix_nxt.last  = at_end;

    s1_valid_nxt = adv ? fire : s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      tgt_x_r    <= '0;
      tgt_y_r    <= '0;
      span_x_r   <= '0;
      span_y_r   <= '0;
      left_r     <= 1'b0;
      up_r       <= 1'b0;
      err_r      <= '0;
      color_r    <= '0;
      layer_r    <= 1'b0;
      active_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (fire) begin
        cur_x_r  <= cur_x_nxt;
        cur_y_r  <= cur_y_nxt;
        tgt_x_r  <= tgt_x_nxt;
        tgt_y_r  <= tgt_y_nxt;
        span_x_r <= span_x_nxt;
        span_y_r <= span_y_nxt;
        left_r   <= left_nxt;
        up_r     <= up_nxt;
        err_r    <= err_nxt;
        color_r  <= color_nxt;
        layer_r  <= layer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) s1_pix_r <= s1_pix_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_pix   = s1_pix_r;

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    fire && at_end |=> !active_r)
    else $error("line still active after its last pixel");

  a_idle_advance_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && adv && !is_start && !active_r |=> !s1_valid_r)
    else $error("advance with no active line produced a pixel");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_take |=> s1_valid_r && $stable(s1_pix_r) && $stable(cur_x_r))
    else $error("pixel stage or line state moved during a stall");

endmodule

// File: hw/rtl/lpg_addr.sv
// Framebuffer address multiply-add and the result register.
// Depends on lpg_pkg.
module lpg_addr (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpg_pkg::cfg_t                 cfg,
  input  logic                          s1_valid,
  input  lpg_pkg::pixel_t               s1_pix,
  output logic                          s1_take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpg_pkg::COORD_BITS-1:0] out_pixel_x,
  output logic [lpg_pkg::COORD_BITS-1:0] out_pixel_y,
  output logic [lpg_pkg::DATA_BITS-1:0]  out_pixel_address,
  output logic [lpg_pkg::DATA_BITS-1:0]  out_pixel_color,
  output logic                          out_last
);
  import lpg_pkg::*;

  logic                                  out_valid_r, out_valid_nxt;
  logic [LIN_BITS-1:0]                   lin;
  logic [DATA_BITS-1:0]                  base, addr_nxt;
  logic [DATA_BITS-1:0]                  addr_r;
  pixel_t                                pix_r;

  assign s1_take = !out_valid_r || out_ready;

  always_comb begin
    lin           = LIN_BITS'(s1_pix.y) * LIN_BITS'(cfg.width) + LIN_BITS'(s1_pix.x);
    base          = s1_pix.layer ? cfg.base1 : cfg.base0;
    addr_nxt      = base + (DATA_BITS'(lin) << 2);
    out_valid_nxt = s1_take ? s1_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_valid) begin
      pix_r  <= s1_pix;
      addr_r <= addr_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = pix_r.x;
  assign out_pixel_y       = pix_r.y;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = pix_r.color;
  assign out_last          = pix_r.last;

endmodule

// File: hw/rtl/line_pixel_generator.sv
// Top level of the Bresenham line rasterizer with framebuffer addressing.
// Depends on lpg_pkg, lpg_stepper and lpg_addr.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    cmd, start/end x/y, color, layer
//   out      source     out_valid/out_ready  pixel x/y, address, color, last
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One beat a cycle while out does not stall: the stepper takes one error-term
// step per cycle, and the address multiply-add sits in the next stage, so a
// pixel passes the stepper's pixel register and then the result register.
// Reset (rst_n low, synchronous) drops any active line, empties both stages
// and loads the register defaults.
// A stall on out holds the result register; in_ready drops only when both
// stages are full.
module line_pixel_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [lpg_pkg::COORD_BITS-1:0] in_start_x,
  input  logic [lpg_pkg::COORD_BITS-1:0] in_start_y,
  input  logic [lpg_pkg::COORD_BITS-1:0] in_end_x,
  input  logic [lpg_pkg::COORD_BITS-1:0] in_end_y,
  input  logic [lpg_pkg::DATA_BITS-1:0]  in_color,
  input  logic                          in_layer,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpg_pkg::COORD_BITS-1:0] out_pixel_x,
  output logic [lpg_pkg::COORD_BITS-1:0] out_pixel_y,
  output logic [lpg_pkg::DATA_BITS-1:0]  out_pixel_address,
  output logic [lpg_pkg::DATA_BITS-1:0]  out_pixel_color,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [lpg_pkg::DATA_BITS-1:0]  cfg_data
);
  import lpg_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   s1_valid, s1_take;
  pixel_t s1_pix;

  // Writes must land only while idle (the user's duty; the block does not enforce it), so no shadowing is needed.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE0: cfg_nxt.base0 = cfg_data;
        CFG_BASE1: cfg_nxt.base1 = cfg_data;
        CFG_WIDTH: cfg_nxt.width = cfg_data[WIDTH_BITS-1:0];
        default:   cfg_nxt = cfg_r;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base0 <= BASE0_RESET;
      cfg_r.base1 <= BASE1_RESET;
      cfg_r.width <= WIDTH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Stage one: line state and step, registered pixel beat.
  lpg_stepper u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .in_color   (in_color),
    .in_layer   (in_layer),
    .s1_take    (s1_take),
    .s1_valid   (s1_valid),
    .s1_pix     (s1_pix)
  );

  // Stage two: address and the result register.
  lpg_addr u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .s1_valid          (s1_valid),
    .s1_pix            (s1_pix),
    .s1_take           (s1_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last          (out_last)
  );

endmodule

// File: bench/line_pixel_generator_tb.sv
// Self-checking bench for line_pixel_generator: random Bresenham lines,
// register phases and handshake stalls, checked against a built-in predictor.
// Depends on lpg_pkg and the line_pixel_generator RTL.
module line_pixel_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpg_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int SETTLE_CYCS = 8;    // pipeline is two deep; allow a margin

  // One input beat as queued for the driver.
  typedef struct {
    cmd_t                  cmd;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [DATA_BITS-1:0]  color;
    logic                  layer;
  } draw_beat_t;

  // One predicted pixel, in the order the block should emit them.
  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [DATA_BITS-1:0]  addr;
    logic [DATA_BITS-1:0]  color;
    logic                  last;
  } expected_pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_cmd = 1'b0;
  logic [COORD_BITS-1:0] in_start_x = '0;
  logic [COORD_BITS-1:0] in_start_y = '0;
  logic [COORD_BITS-1:0] in_end_x = '0;
  logic [COORD_BITS-1:0] in_end_y = '0;
  logic [DATA_BITS-1:0]  in_color = '0;
  logic                  in_layer = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COORD_BITS-1:0] out_pixel_x;
  logic [COORD_BITS-1:0] out_pixel_y;
  logic [DATA_BITS-1:0]  out_pixel_address;
  logic [DATA_BITS-1:0]  out_pixel_color;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [DATA_BITS-1:0]  cfg_data = '0;

  line_pixel_generator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_color          (in_color),
    .in_layer          (in_layer),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  // Stimulus and expectation stores.
  draw_beat_t      pending_beats[$];
  draw_beat_t      beat_on_bus;
  expected_pixel_t pixel_q[$];
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              mismatches = 0;

  // Predictor copy of the registers; these track cfg beats as they land.
  logic [DATA_BITS-1:0]  base0 = BASE0_RESET;
  logic [DATA_BITS-1:0]  base1 = BASE1_RESET;
  logic [WIDTH_BITS-1:0] img_width = WIDTH_RESET;

  // Predictor copy of the line state; everything starts at zero.
  logic [COORD_BITS-1:0]      cur_x = '0;
  logic [COORD_BITS-1:0]      cur_y = '0;
  logic [COORD_BITS-1:0]      tgt_x = '0;
  logic [COORD_BITS-1:0]      tgt_y = '0;
  logic [COORD_BITS-1:0]      span_x = '0;
  logic [COORD_BITS-1:0]      span_y = '0;
  logic                       step_left = 1'b0;
  logic                       step_up = 1'b0;
  logic signed [ERR_BITS-1:0] err_term = '0;
  logic [DATA_BITS-1:0]       line_color = '0;
  logic                       line_layer = 1'b0;
  logic                       line_active = 1'b0;

  // Advance the line state by one accepted beat and queue the pixel it makes.
  // An advance with no line in progress makes nothing and changes nothing.
  function automatic void rasterize_beat(draw_beat_t b);
    int              e2;
    int              e;
    expected_pixel_t px;
    if (b.cmd == CMD_START) begin
      cur_x      = b.sx;
      cur_y      = b.sy;
      tgt_x      = b.ex;
      tgt_y      = b.ey;
      step_left  = !(b.sx < b.ex);
      step_up    = !(b.sy < b.ey);
      span_x     = step_left ? b.sx - b.ex : b.ex - b.sx;
      span_y     = step_up ? b.sy - b.ey : b.ey - b.sy;
      e          = int'(span_x) - int'(span_y);
      err_term   = e[ERR_BITS-1:0];
      line_color = b.color;
      line_layer = b.layer;
    end else begin
      if (!line_active) return;
      e2 = 2 * int'(err_term);
      e  = int'(err_term);
      if (e2 > -int'(span_y)) begin
        e -= int'(span_y);
        cur_x = step_left ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (e2 < int'(span_x)) begin
        e += int'(span_x);
        cur_y = step_up ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      err_term = e[ERR_BITS-1:0];
    end
    // Byte address wraps at 32 bits by construction.
    px.x     = cur_x;
    px.y     = cur_y;
    px.addr  = (line_layer ? base1 : base0)
             + ((32'(cur_y) * 32'(img_width) + 32'(cur_x)) << 2);
    px.color = line_color;
    px.last  = (cur_x == tgt_x) && (cur_y == tgt_y);
    line_active = !px.last;
    pixel_q.push_back(px);
  endfunction

  // Driver: hold each beat until accepted, predict on the accepting edge,
  // then either present the next beat or drop in_valid and idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) rasterize_beat(beat_on_bus);
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_bus = pending_beats.pop_front();
          in_cmd     <= beat_on_bus.cmd;
          in_start_x <= beat_on_bus.sx;
          in_start_y <= beat_on_bus.sy;
          in_end_x   <= beat_on_bus.ex;
          in_end_y   <= beat_on_bus.ey;
          in_color   <= beat_on_bus.color;
          in_layer   <= beat_on_bus.layer;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [DATA_BITS-1:0] want,
                             logic [DATA_BITS-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each accepted pixel with the oldest prediction, and
  // toggle out_ready at the current receiver idle rate.
  always @(posedge clk) begin
    expected_pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel at x=%0d y=%0d", out_pixel_x, out_pixel_y);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_x", 32'(want.x), 32'(out_pixel_x));
          check_field("pixel_y", 32'(want.y), 32'(out_pixel_y));
          check_field("pixel_address", want.addr, out_pixel_address);
          check_field("pixel_color", want.color, out_pixel_color);
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_start(int sx, int sy, int ex, int ey,
                             logic [DATA_BITS-1:0] color, logic layer);
    draw_beat_t b;
    b.cmd   = CMD_START;
    b.sx    = sx[COORD_BITS-1:0];
    b.sy    = sy[COORD_BITS-1:0];
    b.ex    = ex[COORD_BITS-1:0];
    b.ey    = ey[COORD_BITS-1:0];
    b.color = color;
    b.layer = layer;
    pending_beats.push_back(b);
  endtask

  // Advance beats carry random junk in the unused fields so those bits toggle.
  task automatic queue_advances(int n);
    draw_beat_t b;
    repeat (n) begin
      b.cmd   = CMD_ADVANCE;
      b.sx    = COORD_BITS'($urandom_range(COORD_MAX));
      b.sy    = COORD_BITS'($urandom_range(COORD_MAX));
      b.ex    = COORD_BITS'($urandom_range(COORD_MAX));
      b.ey    = COORD_BITS'($urandom_range(COORD_MAX));
      b.color = $urandom;
      b.layer = 1'($urandom_range(1));
      pending_beats.push_back(b);
    end
  endtask

  // Pick an endpoint coordinate near a start one: mostly short spans, a few
  // long ones; reflect back into range when the step runs off the grid.
  function automatic int near_coord(int from);
    int roll;
    int span;
    int to;
    roll = $urandom_range(99);
    if (roll < 85) span = $urandom_range(12);
    else if (roll < 97) span = $urandom_range(64, 13);
    else span = $urandom_range(400, 65);
    to = $urandom_range(1) ? from + span : from - span;
    if (to > COORD_MAX || to < 0) to = 2 * from - to;
    return to;
  endfunction

  // Queue mostly complete lines with random content; mix in abandoned lines,
  // overrun advances and lone advances as noise.
  task automatic queue_random_lines(int budget);
    int count;
    int roll;
    int sx, sy, ex, ey;
    int steps;
    int taken;
    count = 0;
    while (count < budget) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        queue_advances(1);
      end else begin
        sx = $urandom_range(COORD_MAX);
        sy = $urandom_range(COORD_MAX);
        ex = near_coord(sx);
        ey = near_coord(sy);
        queue_start(sx, sy, ex, ey, $urandom, 1'($urandom_range(1)));
        steps = (ex > sx ? ex - sx : sx - ex);
        if ((ey > sy ? ey - sy : sy - ey) > steps) steps = (ey > sy ? ey - sy : sy - ey);
        if (roll < 18) taken = $urandom_range(steps);     // cut short by next start
        else if (roll < 30) taken = steps + $urandom_range(3, 1);  // run past the end
        else taken = steps;
        queue_advances(taken);
        count += 1 + (taken < steps ? taken : steps);
      end
    end
  endtask

  // Wait until every beat is accepted and every pixel is out, then let the
  // pipeline settle: a trailing idle advance produces no pixel to wait on.
  task automatic drain();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || pixel_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCS) @(posedge clk);
  endtask

  // Write all three registers back to back; mirror each one as it lands.
  task automatic write_regs(logic [DATA_BITS-1:0] b0, logic [DATA_BITS-1:0] b1,
                            logic [WIDTH_BITS-1:0] w);
    cfg_index_t            idx[3];
    logic [DATA_BITS-1:0]  val[3];
    idx = '{CFG_BASE0, CFG_BASE1, CFG_WIDTH};
    val = '{b0, b1, 32'(w)};
    @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_BASE0: base0 = val[i];
        CFG_BASE1: base1 = val[i];
        CFG_WIDTH: img_width = val[i][WIDTH_BITS-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 87;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset register values.
    queue_advances(1);                                        // no line yet
    queue_start(0, 0, 0, 0, 32'h0000_0000, 1'b0);             // single point
    queue_advances(1);                                        // line already done
    queue_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF, 1'b1);
    queue_start(0, 0, COORD_MAX, COORD_MAX, 32'h5A5A_A5A5, 1'b0);
    queue_advances(2);
    queue_start(COORD_MAX, 0, 0, COORD_MAX, 32'h8000_0001, 1'b1);  // drop old line
    queue_advances(2);
    queue_start(5, 3, 2, 7, $urandom, 1'b1);                 // down-left, steep
    queue_advances(5);                                        // one past the end
    queue_start(10, 10, 14, 10, $urandom, 1'b0);              // horizontal
    queue_advances(4);
    queue_start(7, 9, 7, 6, $urandom, 1'b1);                  // vertical, upward
    queue_advances(3);
    drain();

    // Random phases: each one rewrites every register, then runs lines.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 87;
        recv_idle_pct = 34;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: write_regs(32'h0000_0000, 32'hFFFF_FFFF, WIDTH_BITS'(COORD_MAX));
        1: write_regs(32'hFFFF_FFFC, 32'hFFF0_0000, 11'd1);   // forces address wrap
        2: write_regs($urandom, $urandom, 11'd0);             // zero width: base + 4x
        3: write_regs($urandom, $urandom, WIDTH_BITS'($urandom_range(COORD_MAX, 1)));
        4: write_regs(BASE0_RESET, BASE1_RESET, WIDTH_RESET);
        default: write_regs($urandom, $urandom, WIDTH_BITS'($urandom_range(COORD_MAX, 1)));
      endcase
      queue_random_lines(205);
      drain();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run under heavy stalls.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
